// ===== rtl/core/cct_pkg.sv =====
// Package for the character class tokenizer: record layouts and codes shared
// by the front end, queue and output stage, and the byte classification functions
// used by the front end. No dependencies.
package cct_pkg;

   localparam int MAX_TOKEN_LEN = 64;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_WARN = 2'd2;

   localparam logic [1:0] CLASS_NUMBER   = 2'd0;
   localparam logic [1:0] CLASS_ALPHA    = 2'd1;
   localparam logic [1:0] CLASS_ALNUM    = 2'd2;
   localparam logic [1:0] CLASS_FRACTION = 2'd3;

   localparam logic [2:0] TERM_BLANK     = 3'd0;
   localparam logic [2:0] TERM_SEPARATOR = 3'd1;
   localparam logic [2:0] TERM_NEWLINE   = 3'd2;
   localparam logic [2:0] TERM_EOS       = 3'd3;
   localparam logic [2:0] TERM_NONE      = 3'd4;

   localparam logic [6:0]  MAX_LEN_VAL = 7'(MAX_TOKEN_LEN);
   localparam logic [15:0] SAT_16      = 16'hFFFF;

   // Fields are declared from the highest bit down, so char_out sits lowest.
   typedef struct packed {
      logic        truncated;
      logic [1:0]  terminator;
      logic [15:0] line_count;
      logic [15:0] token_start;
      logic [6:0]  token_length;
      logic [1:0]  token_class;
      logic [7:0]  char_out;
   } cct_data_type;

   typedef struct packed {
      logic [1:0]   result_kind;
      cct_data_type data;
   } cct_word_type;

   function automatic logic is_ignored(input logic [7:0] c);
      return c == 8'h2B || c == 8'h22 || c == 8'h7B || c == 8'h28 || c == 8'h7E ||
             c == 8'h21 || c == 8'h40 || c == 8'h24 || c == 8'h25 || c == 8'h5E ||
             c == 8'h2A || c == 8'h3D || c == 8'h7C || c == 8'h3F || c == 8'h3C;
   endfunction

   function automatic logic [2:0] term_kind(input logic [7:0] c);
      logic [2:0] k;
      k = TERM_NONE;
      if (c == 8'h20 || c == 8'h2D || c == 8'h2E || c == 8'h29 || c == 8'h7D ||
          c == 8'h3E || c == 8'h5F) begin
         k = TERM_BLANK;
      end else if (c == 8'h09 || c == 8'h2C || c == 8'h3B) begin
         k = TERM_SEPARATOR;
      end else if (c == 8'h0A || c == 8'h0D || c == 8'h0C) begin
         k = TERM_NEWLINE;
      end else if (c == 8'h00) begin
         k = TERM_EOS;
      end
      return k;
   endfunction

endpackage

// ===== rtl/core/char_class_tokenizer.sv =====
// Top level of the character class tokenizer: front end, result queue and
// output stage. Depends on cct_pkg, cct_front, cct_queue and cct_back.
//
// Usage: text bytes enter on the req_ channel, one byte per word; a zero byte
// ends a string. Each byte yields no word or one word on the rsp_ channel:
// a token character, a token end record or an unexpected byte warning, with
// the kind in rsp_tuser. Line and offset counting restart after a zero byte.
// A byte is taken every cycle while the four-entry queue has room; a result
// word is written into the queue at the edge that accepts its byte, then
// loaded into the output register and presented on rsp_; that register can
// deliver one word per cycle while the receiver is ready, so the sustained
// rate is one byte per cycle, set by the combinational classify and the
// registered state update in the front end. When the receiver stalls, the
// output register holds its word and the queue fills; once it is full
// req_tready falls until a word is taken. Reset clears the token state,
// sets the line number to one, and empties the queue and output register.
module char_class_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] char_out, [9:8] token_class,
                                    // [16:10] token_length, [32:17] token_start,
                                    // [48:33] line_count, [50:49] terminator,
                                    // [51] truncated, [55:52] zero
   output logic [1:0]  rsp_tuser    // [1:0] result_kind
);
   import cct_pkg::*;

   logic         accept;
   logic         push;
   cct_word_type push_word;
   logic         pop;
   logic         queue_full;
   logic         queue_empty;
   cct_word_type head_word;
   cct_word_type out_word;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   cct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_byte (req_tdata),
      .push      (push),
      .push_word (push_word)
   );

   cct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head_word (head_word)
   );

   cct_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_word   (head_word),
      .pop         (pop),
      .out_ready   (rsp_tready),
      .out_valid   (rsp_tvalid),
      .out_word    (out_word)
   );

   assign rsp_tdata = {4'b0000, out_word.data};
   assign rsp_tuser = out_word.result_kind;

endmodule

// ===== rtl/core/cct_front.sv =====
// Front end of the tokenizer: classifies each byte, keeps the per-string
// token state and pushes at most one result word per byte into the queue.
// Depends on cct_pkg.
module cct_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            char_byte,
   output logic                  push,
   output cct_pkg::cct_word_type push_word
);
   import cct_pkg::*;

   logic        open_ff,        open_in;
   logic [1:0]  class_ff,       class_in;
   logic [6:0]  length_ff,      length_in;
   logic [15:0] start_ff,       start_in;
   logic [15:0] offset_ff,      offset_in;
   logic [15:0] line_ff,        line_in;
   logic        overflowed_ff,  overflowed_in;

   logic       is_digit;
   logic       is_alpha;
   logic       is_slash;
   logic [2:0] tk;

   assign is_digit = char_byte >= 8'h30 && char_byte <= 8'h39;
   assign is_alpha = (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                     (char_byte >= 8'h61 && char_byte <= 8'h7A);
   assign is_slash = char_byte == 8'h2F;
   assign tk       = term_kind(char_byte);

   always_comb begin
      open_in       = open_ff;
      class_in      = class_ff;
      length_in     = length_ff;
      start_in      = start_ff;
      offset_in     = offset_ff;
      line_in       = line_ff;
      overflowed_in = overflowed_ff;
      push          = 1'b0;
      push_word     = '0;
      if (accept) begin
         if (offset_ff != SAT_16) begin
            offset_in = offset_ff + 16'd1;
         end
         if (is_ignored(char_byte)) begin
            push = 1'b0;
         end else if (tk != TERM_NONE) begin
            if (open_ff) begin
               push                        = 1'b1;
               push_word.result_kind       = KIND_END;
               push_word.data.token_class  = class_ff;
               push_word.data.token_length = length_ff;
               push_word.data.token_start  = start_ff;
               push_word.data.line_count   = line_ff;
               push_word.data.terminator   = tk[1:0];
               push_word.data.truncated    = overflowed_ff;
               if ((tk == TERM_NEWLINE || tk == TERM_EOS) && line_ff != SAT_16) begin
                  line_in = line_ff + 16'd1;
               end
               open_in       = 1'b0;
               length_in     = '0;
               start_in      = '0;
               overflowed_in = 1'b0;
            end
            if (tk == TERM_EOS) begin
               open_in       = 1'b0;
               length_in     = '0;
               start_in      = '0;
               offset_in     = '0;
               line_in       = 16'd1;
               overflowed_in = 1'b0;
            end
         end else if (is_digit || is_alpha || is_slash) begin
            if (length_ff >= MAX_LEN_VAL) begin
               overflowed_in = 1'b1;
            end else begin
               if (is_digit) begin
                  if (!open_ff) begin
                     open_in  = 1'b1;
                     class_in = CLASS_NUMBER;
                  end else if (class_ff == CLASS_ALPHA) begin
                     class_in = CLASS_ALNUM;
                  end
               end else if (is_alpha) begin
                  if (!open_ff) begin
                     open_in  = 1'b1;
                     class_in = CLASS_ALPHA;
                  end else if (class_ff == CLASS_NUMBER) begin
                     class_in = CLASS_ALNUM;
                  end
               end else if (open_ff && class_ff == CLASS_NUMBER) begin
                  class_in = CLASS_FRACTION;
               end
               if (length_ff == '0) begin
                  start_in = offset_ff;
               end
               length_in                = length_ff + 7'd1;
               push                     = 1'b1;
               push_word.result_kind    = KIND_CHAR;
               push_word.data.char_out  = char_byte;
            end
         end else begin
            push                    = 1'b1;
            push_word.result_kind   = KIND_WARN;
            push_word.data.char_out = char_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff       <= 1'b0;
         class_ff      <= CLASS_NUMBER;
         length_ff     <= '0;
         start_ff      <= '0;
         offset_ff     <= '0;
         line_ff       <= 16'd1;
         overflowed_ff <= 1'b0;
      end else begin
         open_ff       <= open_in;
         class_ff      <= class_in;
         length_ff     <= length_in;
         start_ff      <= start_in;
         offset_ff     <= offset_in;
         line_ff       <= line_in;
         overflowed_ff <= overflowed_in;
      end
   end

endmodule

// ===== rtl/core/cct_queue.sv =====
// Short first-in first-out queue of result words between front end and
// output stage, held in flip-flops.
// Depends on cct_pkg.
module cct_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cct_pkg::cct_word_type push_word,
   input  logic                  pop,
   output logic                  full,
   output logic                  empty,
   output cct_pkg::cct_word_type head_word
);
   import cct_pkg::*;

   cct_word_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]         count_ff,  count_in;

   assign full      = count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign head_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/core/cct_back.sv =====
// Output stage of the tokenizer: takes words from the queue into a
// registered result channel and holds them while the receiver stalls.
// Depends on cct_pkg.
module cct_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  cct_pkg::cct_word_type head_word,
   output logic                  pop,
   input  logic                  out_ready,
   output logic                  out_valid,
   output cct_pkg::cct_word_type out_word
);
   import cct_pkg::*;

   logic         valid_ff, valid_in;
   cct_word_type word_ff,  word_in;

   assign pop       = !queue_empty && (!valid_ff || out_ready);
   assign valid_in  = pop || (valid_ff && !out_ready);
   assign word_in   = pop ? head_word : word_ff;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for char_class_tokenizer: drives text bytes with
// random gaps, predicts every result word and checks each field of it.
// Depends on cct_pkg and the char_class_tokenizer RTL.
module tb_top;
   import cct_pkg::*;

   typedef enum logic [2:0] {
      GRP_IGNORED, GRP_TERM, GRP_DIGIT, GRP_ALPHA, GRP_SLASH, GRP_OTHER
   } byte_group_type;

   localparam int          TEXT_BYTES   = 1400;
   localparam int          PRINT_LIMIT  = 200;
   localparam logic [7:0]  SLASH_BYTE   = 8'h2F;
   localparam logic [7:0]  NUL_BYTE     = 8'h00;

   // Space-class, delimiter, end-of-line and end-of-string bytes.
   localparam logic [7:0] TERM_BYTES [14] = '{
      8'h20, 8'h2D, 8'h2E, 8'h29, 8'h7D, 8'h3E, 8'h5F,
      8'h09, 8'h2C, 8'h3B, 8'h0A, 8'h0D, 8'h0C, 8'h00
   };
   localparam logic [7:0] SKIP_BYTES [15] = '{
      8'h2B, 8'h22, 8'h7B, 8'h28, 8'h7E, 8'h21, 8'h40, 8'h24,
      8'h25, 8'h5E, 8'h2A, 8'h3D, 8'h7C, 8'h3F, 8'h3C
   };
   // Fraction, alphanumeric, lone slash reopened by a letter, ignored and
   // unexpected bytes, a terminator with nothing open, and a zero byte.
   localparam logic [7:0] OPENING_TEXT [25] = '{
      8'h37, 8'h2F, 8'h33, 8'h20, 8'h41, 8'h7A, 8'h39, 8'h2C,
      8'h30, 8'h39, 8'h61, 8'h0A, 8'h2F, 8'h20, 8'h62, 8'h0D,
      8'h2B, 8'h80, 8'hFF, 8'h01, 8'h3B, 8'h5A, 8'h0C, 8'h71, 8'h00
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   logic [7:0]   text_bytes [$];
   cct_word_type awaited_words [$];
   int unsigned  mismatch_count = 0;

   // Tokenizer state as seen by the predictor.
   logic        tok_open    = 1'b0;
   logic [1:0]  tok_class   = '0;
   logic [6:0]  tok_len     = '0;
   logic [15:0] tok_start   = '0;
   logic [15:0] str_offset  = '0;
   logic [15:0] line_no     = 16'd1;
   logic        tok_dropped = 1'b0;

   int unsigned send_wait  = 0;
   int unsigned recv_wait  = 0;
   int unsigned recv_next;
   logic        send_calm  = 1'b0;
   logic        recv_calm  = 1'b0;

   char_class_tokenizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int unsigned draw_gap(input logic calm);
      return calm ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic logic [7:0] digit_byte();
      return 8'($urandom_range(8'h30, 8'h39));
   endfunction

   function automatic logic [7:0] letter_byte();
      return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                  : 8'($urandom_range(8'h61, 8'h7A));
   endfunction

   function automatic byte_group_type group_of(input logic [7:0] c, output logic [2:0] tk);
      tk = TERM_NONE;
      case (c)
         8'h20, 8'h2D, 8'h2E, 8'h29, 8'h7D, 8'h3E, 8'h5F: tk = TERM_BLANK;
         8'h09, 8'h2C, 8'h3B:                              tk = TERM_SEPARATOR;
         8'h0A, 8'h0D, 8'h0C:                              tk = TERM_NEWLINE;
         8'h00:                                            tk = TERM_EOS;
         default: ;
      endcase
      if (tk != TERM_NONE) return GRP_TERM;
      foreach (SKIP_BYTES[i]) begin
         if (c == SKIP_BYTES[i]) return GRP_IGNORED;
      end
      if (c inside {[8'h30:8'h39]}) return GRP_DIGIT;
      if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) return GRP_ALPHA;
      if (c == SLASH_BYTE) return GRP_SLASH;
      return GRP_OTHER;
   endfunction

   task automatic close_token();
      tok_open    = 1'b0;
      tok_class   = '0;
      tok_len     = '0;
      tok_start   = '0;
      tok_dropped = 1'b0;
   endtask

   task automatic tokenize_byte(input logic [7:0] c);
      cct_word_type   w;
      logic [15:0]    here;
      logic [2:0]     tk;
      byte_group_type grp;
      w    = '0;
      here = str_offset;
      if (str_offset != SAT_16) str_offset++;
      grp = group_of(c, tk);
      case (grp)
         GRP_TERM: begin
            if (tok_open) begin
               w.result_kind       = KIND_END;
               w.data.token_class  = tok_class;
               w.data.token_length = tok_len;
               w.data.token_start  = tok_start;
               w.data.line_count   = line_no;
               w.data.terminator   = tk[1:0];
               w.data.truncated    = tok_dropped;
               awaited_words.push_back(w);
               if ((tk == TERM_NEWLINE || tk == TERM_EOS) && line_no != SAT_16) line_no++;
               close_token();
            end
            if (tk == TERM_EOS) begin
               close_token();
               str_offset = '0;
               line_no    = 16'd1;
            end
         end
         GRP_DIGIT, GRP_ALPHA, GRP_SLASH: begin
            if (tok_len >= MAX_LEN_VAL) begin
               tok_dropped = 1'b1;
            end else begin
               if (grp == GRP_DIGIT) begin
                  if (!tok_open) begin
                     tok_open  = 1'b1;
                     tok_class = CLASS_NUMBER;
                  end else if (tok_class == CLASS_ALPHA) begin
                     tok_class = CLASS_ALNUM;
                  end
               end else if (grp == GRP_ALPHA) begin
                  if (!tok_open) begin
                     tok_open  = 1'b1;
                     tok_class = CLASS_ALPHA;
                  end else if (tok_class == CLASS_NUMBER) begin
                     tok_class = CLASS_ALNUM;
                  end
               end else if (tok_open && tok_class == CLASS_NUMBER) begin
                  tok_class = CLASS_FRACTION;
               end
               if (tok_len == '0) tok_start = here;
               tok_len++;
               w.result_kind   = KIND_CHAR;
               w.data.char_out = c;
               awaited_words.push_back(w);
            end
         end
         GRP_OTHER: begin
            w.result_kind   = KIND_WARN;
            w.data.char_out = c;
            awaited_words.push_back(w);
         end
         default: ;
      endcase
   endtask

   task automatic report(input string what, input logic [55:0] want, input logic [55:0] got);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   task automatic check_word(input logic [1:0] kind, input logic [55:0] data);
      cct_word_type want;
      cct_data_type got;
      got = data[51:0];
      if (awaited_words.size() == 0) begin
         report("unexpected word, data", '0, data);
         return;
      end
      want = awaited_words.pop_front();
      if (kind != want.result_kind)
         report("result_kind", 56'(want.result_kind), 56'(kind));
      if (got.char_out != want.data.char_out)
         report("char_out", 56'(want.data.char_out), 56'(got.char_out));
      if (got.token_class != want.data.token_class)
         report("token_class", 56'(want.data.token_class), 56'(got.token_class));
      if (got.token_length != want.data.token_length)
         report("token_length", 56'(want.data.token_length), 56'(got.token_length));
      if (got.token_start != want.data.token_start)
         report("token_start", 56'(want.data.token_start), 56'(got.token_start));
      if (got.line_count != want.data.line_count)
         report("line_count", 56'(want.data.line_count), 56'(got.line_count));
      if (got.terminator != want.data.terminator)
         report("terminator", 56'(want.data.terminator), 56'(got.terminator));
      if (got.truncated != want.data.truncated)
         report("truncated", 56'(want.data.truncated), 56'(got.truncated));
      if (data[55:52] != 4'd0) report("padding", '0, 56'(data[55:52]));
   endtask

   // A well-formed token with random content and a random terminator; a few
   // are long enough to overflow, and some begin with a lone slash.
   task automatic add_token();
      int unsigned len;
      int unsigned flavour;
      len     = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 8);
      flavour = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) text_bytes.push_back(SLASH_BYTE);
      for (int unsigned i = 0; i < len; i++) begin
         case (flavour)
            0: text_bytes.push_back(digit_byte());
            1: text_bytes.push_back(letter_byte());
            2: begin
               case ($urandom_range(0, 4))
                  0:       text_bytes.push_back(SLASH_BYTE);
                  1, 2:    text_bytes.push_back(digit_byte());
                  default: text_bytes.push_back(letter_byte());
               endcase
            end
            default: text_bytes.push_back((i == len / 2 && len > 1) ? SLASH_BYTE : digit_byte());
         endcase
      end
      text_bytes.push_back(TERM_BYTES[$urandom_range(0, $size(TERM_BYTES) - 1)]);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait  <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) tokenize_byte(req_tdata);
         if (send_wait != 0) begin
            req_tvalid <= 1'b0;
            send_wait  <= send_wait - 1;
         end else if (text_bytes.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= text_bytes.pop_front();
            send_wait  <= draw_gap(send_calm);
            if ($urandom_range(0, 49) == 0) send_calm <= !send_calm;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_word(rsp_tuser, rsp_tdata);
            recv_next = draw_gap(recv_calm);
            if ($urandom_range(0, 49) == 0) recv_calm <= !recv_calm;
         end else begin
            recv_next = (recv_wait != 0) ? recv_wait - 1 : 0;
         end
         recv_wait  <= recv_next;
         rsp_tready <= (recv_next == 0);
      end
   end

   initial begin
      foreach (OPENING_TEXT[i]) text_bytes.push_back(OPENING_TEXT[i]);
      while (text_bytes.size() < TEXT_BYTES) begin
         case ($urandom_range(0, 19))
            0, 1, 2:  text_bytes.push_back(8'($urandom_range(0, 255)));
            3, 4:     text_bytes.push_back(SKIP_BYTES[$urandom_range(0, $size(SKIP_BYTES) - 1)]);
            5:        text_bytes.push_back(NUL_BYTE);
            default:  add_token();
         endcase
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (text_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && awaited_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== char_class_tokenizer.f =====
rtl/core/cct_pkg.sv
rtl/core/cct_front.sv
rtl/core/cct_queue.sv
rtl/core/cct_back.sv
rtl/core/char_class_tokenizer.sv
dv/tb_top.sv
